// File: sv/ghcb_pkg.sv
// Shared types and constants for the gear hash chunk boundary unit.
`default_nettype none

package ghcb_pkg;

    // Fixed field widths
    localparam int HASH_BITS     = 64;
    localparam int OFFSET_BITS   = 40;
    localparam int LEN_BITS      = 24;
    localparam int LOG2_BITS     = 6;
    localparam int BYTE_BITS     = 8;
    localparam int TABLE_ENTRIES = 256;
    localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MIN_CHUNK = 2'd0,
        CFG_AVG_LOG2  = 2'd1,
        CFG_MAX_CHUNK = 2'd2
    } cfg_index_t;

    // Cut causes
    typedef enum logic [1:0] {
        CAUSE_CONTENT = 2'd0,
        CAUSE_MAX     = 2'd1,
        CAUSE_END     = 2'd2
    } cause_t;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    // Data item after the table lookup
    typedef struct packed {
        logic [HASH_BITS-1:0] gear_word;
        logic                 end_of_data;
    } item_t;

    // Active configuration seen by the back end
    typedef struct packed {
        logic [LEN_BITS-1:0]  min_chunk_size;
        logic [LEN_BITS-1:0]  max_chunk_size;
        logic [HASH_BITS-1:0] cut_mask;
    } cfg_t;

    // Low-ones mask for the content test
    function automatic logic [HASH_BITS-1:0] low_mask(input logic [LOG2_BITS-1:0] bits);
        logic [HASH_BITS-1:0] one;
        one = {{(HASH_BITS-1){1'b0}}, 1'b1};
        return (one << bits) - one;
    endfunction

endpackage

`default_nettype wire

// File: sv/ghcb_front.sv
// Front end: accepts items, loads the gear table and looks up data bytes.
`default_nettype none

module ghcb_front
    import ghcb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 in_mode,
    input  wire logic [BYTE_BITS-1:0] in_byte,
    input  wire logic                 in_last,
    input  wire logic [TABLE_AW-1:0]  in_index,
    input  wire logic [HASH_BITS-1:0] in_word,
    input  wire logic [QCNT_BITS-1:0] q_count,
    output logic                      push,
    output item_t                     push_item
);

    logic [HASH_BITS-1:0] gear_mem [TABLE_ENTRIES];
    logic [HASH_BITS-1:0] rd_word_reg;
    logic                 last_reg;
    logic                 stage_valid_reg;
    logic                 accept;
    logic [QCNT_BITS:0]   pending;

    // Room for the item in flight plus the new one
    assign pending  = {1'b0, q_count} + {{QCNT_BITS{1'b0}}, stage_valid_reg};
    assign in_ready = pending < (QCNT_BITS+1)'(QUEUE_DEPTH);
    assign accept   = in_valid && in_ready;

    // Gear table: write on table items, registered read on data items
    always_ff @(posedge clk)
    begin
        if (accept && in_mode)
        begin
            gear_mem[in_index] <= in_word;
        end
        if (accept && !in_mode)
        begin
            rd_word_reg <= gear_mem[in_byte];
            last_reg    <= in_last;
        end
    end

    // Lookup stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= accept && !in_mode;
        end
    end

    assign push                  = stage_valid_reg;
    assign push_item.gear_word   = rd_word_reg;
    assign push_item.end_of_data = last_reg;

endmodule

`default_nettype wire

// File: sv/ghcb_queue.sv
// Short queue of looked-up items between front and back.
`default_nettype none

module ghcb_queue
    import ghcb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire item_t                push_item,
    input  wire logic                 pop,
    output logic                      head_valid,
    output item_t                     head_item,
    output logic [QCNT_BITS-1:0]      count
);

    item_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_pop;

    assign head_valid = count_reg != '0;
    assign head_item  = entry_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/ghcb_back.sv
// Back end: gear hash recurrence, cut decision and result register.
`default_nettype none

module ghcb_back
    import ghcb_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cfg_t                   cfg,
    input  wire logic                   head_valid,
    input  wire item_t                  head_item,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [OFFSET_BITS-1:0]      out_offset,
    output logic [LEN_BITS-1:0]         out_length,
    output cause_t                      out_cause,
    output logic [HASH_BITS-1:0]        out_hash
);

    logic [HASH_BITS-1:0]   hash_reg,  hash_next;
    logic [LEN_BITS-1:0]    len_reg,   len_next;
    logic [OFFSET_BITS-1:0] start_reg;
    logic [OFFSET_BITS-1:0] pos_reg,   pos_next;
    logic                   out_valid_reg;
    logic [OFFSET_BITS-1:0] out_offset_reg;
    logic [LEN_BITS-1:0]    out_length_reg;
    cause_t                 out_cause_reg;
    logic [HASH_BITS-1:0]   out_hash_reg;
    logic                   content, at_max, cut;
    cause_t                 cause;

    // Take the next item whenever the result slot is free or draining
    assign pop = head_valid && (!out_valid_reg || out_ready);

    // Hash, length and position for this byte
    always_comb
    begin
        hash_next = {hash_reg[HASH_BITS-2:0], 1'b0} + head_item.gear_word;
        len_next  = len_reg + 1'b1;
        pos_next  = (pos_reg == OFFSET_MAX) ? pos_reg : pos_reg + 1'b1;
        content   = (len_next >= cfg.min_chunk_size) && ((hash_next & cfg.cut_mask) == '0);
        at_max    = len_next >= cfg.max_chunk_size;
        cut       = content || at_max || head_item.end_of_data;
        if (content)
        begin
            cause = CAUSE_CONTENT;
        end
        else if (at_max)
        begin
            cause = CAUSE_MAX;
        end
        else
        begin
            cause = CAUSE_END;
        end
    end

    // Chunk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= '0;
            len_reg   <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
        end
        else if (pop)
        begin
            pos_reg <= pos_next;
            if (cut)
            begin
                hash_reg  <= '0;
                len_reg   <= '0;
                start_reg <= pos_next;
            end
            else
            begin
                hash_reg <= hash_next;
                len_reg  <= len_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop && cut)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && cut)
        begin
            out_offset_reg <= start_reg;
            out_length_reg <= len_next;
            out_cause_reg  <= cause;
            out_hash_reg   <= hash_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_offset = out_offset_reg;
    assign out_length = out_length_reg;
    assign out_cause  = out_cause_reg;
    assign out_hash   = out_hash_reg;

endmodule

`default_nettype wire

// File: sv/gear_hash_chunk_boundary_unit.sv
// Top level of the gear hash chunk boundary unit.
//
// Content-defined chunking of a byte stream with a 64-bit gear hash.
// Input stream: one item per beat. tuser = 0 carries a data byte (tdata[7:0],
// tlast marks the last byte of the stream); tuser = 1 writes gear table
// entry tdata[15:8] with tdata[79:16]. Every entry must be loaded before
// a data byte that uses it arrives.
// Output stream: one item per cut, giving offset, length, hash and the cause
// in tuser (content boundary, maximum size, end of data).
// Configuration: cfg_we with cfg_index selects min size, log2 average size
// or max size; write only while the unit is idle.
// Throughput: one item per cycle while the output does not stall. A data byte
// goes through the gear table read register, then the queue, where it waits
// while the output stalls, then the result register. The table read sits
// ahead of the hash loop, whose shift and add is combinational into hash_reg.
// Reset clears the hash, chunk length, chunk start and stream position and
// loads the default configuration; the gear table is not cleared.
// When the output stalls, the back end holds, the four-entry queue fills and
// s_tready drops once the queue and the lookup stage together hold four items.
`default_nettype none

module gear_hash_chunk_boundary_unit
    import ghcb_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // data_byte, table_index, table_word
    input  wire logic [79:0]             s_tdata,
    // mode
    input  wire logic                    s_tuser,
    input  wire logic                    s_tlast,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // chunk_offset, chunk_length, boundary_hash
    output logic [127:0]                 m_tdata,
    // end_cause
    output logic [1:0]                   m_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [LEN_BITS-1:0]     cfg_data
);

    logic [LEN_BITS-1:0]    min_size_reg;
    logic [LEN_BITS-1:0]    max_size_reg;
    logic [HASH_BITS-1:0]   mask_reg;
    cfg_t                   cfg;
    logic                   push;
    item_t                  push_item;
    logic                   pop;
    logic                   head_valid;
    item_t                  head_item;
    logic [QCNT_BITS-1:0]   q_count;
    logic [OFFSET_BITS-1:0] out_offset;
    logic [LEN_BITS-1:0]    out_length;
    cause_t                 out_cause;
    logic [HASH_BITS-1:0]   out_hash;

    // Configuration registers; the content mask is kept ready-made
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_size_reg <= LEN_BITS'(2048);
            max_size_reg <= LEN_BITS'(65536);
            mask_reg     <= low_mask(LOG2_BITS'(13));
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_CHUNK: min_size_reg <= cfg_data;
                CFG_AVG_LOG2:  mask_reg     <= low_mask(cfg_data[LOG2_BITS-1:0]);
                CFG_MAX_CHUNK: max_size_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cfg.min_chunk_size = min_size_reg;
    assign cfg.max_chunk_size = max_size_reg;
    assign cfg.cut_mask       = mask_reg;

    ghcb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_byte   (s_tdata[7:0]),
        .in_last   (s_tlast),
        .in_index  (s_tdata[15:8]),
        .in_word   (s_tdata[79:16]),
        .q_count   (q_count),
        .push      (push),
        .push_item (push_item)
    );

    ghcb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .count      (q_count)
    );

    ghcb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_offset (out_offset),
        .out_length (out_length),
        .out_cause  (out_cause),
        .out_hash   (out_hash)
    );

    assign m_tdata = {out_hash, out_length, out_offset};
    assign m_tuser = out_cause;

endmodule

`default_nettype wire
